// ===== hw/rtl/literal_stream_substitute_assert.svh =====
// Assertion macros shared by the literal stream substitute modules.
`ifndef LITERAL_STREAM_SUBSTITUTE_ASSERT_SVH
`define LITERAL_STREAM_SUBSTITUTE_ASSERT_SVH

`ifndef SYNTHESIS
`define LSS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("literal_stream_substitute: assertion failed");
`define LSS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("literal_stream_substitute: forbidden condition seen");
`else
`define LSS_ASSERT(label, clk, rst, prop)
`define LSS_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== hw/rtl/lss_pkg.sv =====
// Types and constants shared by the literal stream substitute modules.
`default_nettype none

package lss_pkg;

  localparam int REPL_MAX    = 8;
  localparam int CNT_W       = 4;
  localparam int COUNT_W     = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 6;
  localparam int DATA_W      = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_PLEN   = 3'd0,
    REG_PBYTES = 3'd1,
    REG_RLEN   = 3'd2,
    REG_RBYTES = 3'd3,
    REG_LIMIT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]         plen;
    logic [63:0]        pbytes;
    logic [3:0]         rlen;
    logic [63:0]        rbytes;
    logic [COUNT_W-1:0] limit;
    logic               plen_wr;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        data;
    logic [CNT_W-1:0]   cnt;
    logic               last;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lss_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module lss_regs
  import lss_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [3:0]         plen;
  logic [63:0]        pbytes;
  logic [3:0]         rlen;
  logic [63:0]        rbytes;
  logic [COUNT_W-1:0] limit;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plen    <= 4'd1;
      pbytes  <= '0;
      rlen    <= '0;
      rbytes  <= '0;
      limit   <= COUNT_MAX;
    end else begin
      if (wr_en) begin
        case (idx)
          REG_PLEN:   plen   <= pwdata[3:0];
          REG_PBYTES: pbytes <= pwdata;
          REG_RLEN:   rlen   <= pwdata[3:0];
          REG_RBYTES: rbytes <= pwdata;
          REG_LIMIT:  limit  <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_PLEN:   prdata = {60'd0, plen};
      REG_PBYTES: prdata = pbytes;
      REG_RLEN:   prdata = {60'd0, rlen};
      REG_RBYTES: prdata = rbytes;
      REG_LIMIT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, limit};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.plen    = plen;
    cfg.pbytes  = pbytes;
    cfg.rlen    = rlen;
    cfg.rbytes  = rbytes;
    cfg.limit   = limit;
    cfg.plen_wr = wr_en & (idx == REG_PLEN);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lss_fifo.sv =====
// Short job queue between the front end and the back end.
`default_nettype none
`include "literal_stream_substitute_assert.svh"

module lss_fifo
  import lss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  job_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LSS_ASSERT_NEVER(a_fifo_underflow, clk, rst, pop && empty)
  `LSS_ASSERT(a_fifo_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== hw/rtl/lss_front.sv =====
// Front end: window update, pattern compare and job building for each input item.
`default_nettype none
`include "literal_stream_substitute_assert.svh"

module lss_front
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       full,
  output logic       push,
  output job_t       job
);

  localparam int FILL_W = $clog2(PATTERN_MAX + 1);

  logic [7:0]         win [PATTERN_MAX];
  logic [FILL_W-1:0]  fill;
  logic [COUNT_W-1:0] emitted;
  logic [COUNT_W-1:0] match_cnt;

  logic [7:0]         w   [PATTERN_MAX];
  logic [7:0]         wsh [PATTERN_MAX];
  logic [7:0]         win_next [PATTERN_MAX];
  logic [FILL_W-1:0]  fill_next;
  logic [FILL_W-1:0]  f0;
  logic [FILL_W-1:0]  f1;
  logic [3:0]         plen;
  logic [3:0]         rlen;
  logic               at_len;
  logic               hit;
  logic [CNT_W-1:0]   k;
  logic [63:0]        data;
  logic [63:0]        wdata;
  logic [COUNT_W-1:0] room;
  logic [CNT_W-1:0]   allowed;
  logic [COUNT_W-1:0] match_inc;
  logic               accept;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign push     = accept & ((allowed != '0) | in_last);

  always_comb begin
    plen = cfg.plen;
    if (plen == 4'd0) begin
      plen = 4'd1;
    end
    if (plen > 4'(PATTERN_MAX)) begin
      plen = 4'(PATTERN_MAX);
    end
    rlen = (cfg.rlen > 4'(REPL_MAX)) ? 4'(REPL_MAX) : cfg.rlen;

    f0 = (fill >= FILL_W'(PATTERN_MAX)) ? '0 : fill;
    f1 = f0 + 1'b1;
    at_len = (4'(f1) >= plen);

    wdata = '0;
    hit   = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      w[i] = (FILL_W'(i) == f0) ? in_byte : win[i];
      wdata[8*i +: 8] = w[i];
      if ((4'(i) < plen) && (w[i] != cfg.pbytes[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      wsh[i] = (i + 1 < PATTERN_MAX) ? w[(i + 1) % PATTERN_MAX] : w[i];
    end

    if (at_len && hit) begin
      data = cfg.rbytes;
      k    = rlen;
    end else if (at_len) begin
      data = wdata;
      k    = in_last ? CNT_W'(f1) : CNT_W'(1);
    end else begin
      data = wdata;
      k    = in_last ? CNT_W'(f1) : '0;
    end

    room    = (cfg.limit > emitted) ? (cfg.limit - emitted) : '0;
    allowed = ({{(COUNT_W-CNT_W){1'b0}}, k} > room) ? room[CNT_W-1:0] : k;

    match_inc = (at_len && hit && (match_cnt != COUNT_MAX)) ? (match_cnt + 1'b1) : match_cnt;

    if (in_last || (at_len && hit)) begin
      win_next  = w;
      fill_next = '0;
    end else if (at_len) begin
      win_next  = wsh;
      fill_next = f1 - 1'b1;
    end else begin
      win_next  = w;
      fill_next = f1;
    end

    job.data  = data;
    job.cnt   = allowed;
    job.last  = in_last;
    job.count = match_inc;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      emitted   <= '0;
      match_cnt <= '0;
    end else begin
      if (cfg.plen_wr) begin
        fill <= '0;
      end else if (accept) begin
        fill <= fill_next;
      end
      if (accept) begin
        emitted   <= in_last ? '0 : (emitted + COUNT_W'(allowed));
        match_cnt <= in_last ? '0 : match_inc;
      end
    end
  end

  `LSS_ASSERT(a_fill_below_max, clk, rst, fill < FILL_W'(PATTERN_MAX))
  `LSS_ASSERT(a_last_clears, clk, rst, accept && in_last |=> (fill == '0) && (match_cnt == '0))

endmodule

`default_nettype wire

// ===== hw/rtl/lss_back.sv =====
// Back end: walks queued jobs, one result item per cycle unless stalled.
`default_nettype none
`include "literal_stream_substitute_assert.svh"

module lss_back
  import lss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  job_t               head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               out_last,
  output logic [COUNT_W-1:0] replace_count
);

  logic [CNT_W-2:0] idx;
  logic             advance;
  logic             final_byte;

  assign advance    = ~empty & (~out_valid | ~out_stall);
  assign final_byte = (head.cnt == '0) || ({1'b0, idx} == (head.cnt - 1'b1));
  assign pop        = advance & final_byte;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte      <= (head.cnt == '0) ? 8'd0 : head.data[8*idx +: 8];
      byte_valid    <= (head.cnt != '0);
      out_last      <= head.last & final_byte;
      replace_count <= (head.last & final_byte) ? head.count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? '0 : (idx + 1'b1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LSS_ASSERT(a_bare_marker_is_last, clk, rst, out_valid && !byte_valid |-> out_last)
  `LSS_ASSERT(a_idx_in_job, clk, rst, !empty && (head.cnt != '0) |-> ({1'b0, idx} < head.cnt))

endmodule

`default_nettype wire

// ===== hw/rtl/literal_stream_substitute.sv =====
// Top level of the streaming literal find-and-replace block.
`default_nettype none

// The block replaces every leftmost, non-overlapping occurrence of a pattern of up to
// PATTERN_MAX bytes in the input stream with a replacement of 0 to 8 bytes, flushes the
// window on the item marked last and then reports the saturating replacement count on the
// final result item. A front end takes one input item per cycle while the queue is not
// full, updates the window and places a job holding up to eight output bytes into a
// two-entry queue; a back end presents one result item per cycle from that queue while
// out_stall is low. While the back end walks an item that yields several results, the
// input is stalled once the queue is full. The first result of an item is written into
// the queue and then registered at the back end's output. No clearing pass is needed
// after reset. Configuration is written through the APB-style port at byte address 8*i.

module literal_stream_substitute
  import lss_pkg::*;
#(
  parameter int PATTERN_MAX = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               out_last,
  output logic [COUNT_W-1:0] replace_count
);

  cfg_t cfg;
  job_t wr_job;
  job_t head;
  logic push;
  logic pop;
  logic empty;
  logic full;

  lss_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lss_front #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .full     (full),
    .push     (push),
    .job      (wr_job)
  );

  lss_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  lss_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .out_last      (out_last),
    .replace_count (replace_count)
  );

endmodule

`default_nettype wire
